// ===== rtl/core/lpdp_pkg.sv =====
// Package for the lidar point depth projection block.
// Widths, pipeline depths, register indexes and the configuration struct.
// No dependencies.
`default_nettype none
package lpdp_pkg;

   // image and point geometry
   localparam int MAX_IMAGE_DIM = 4096;
   localparam int Q_W     = $clog2(MAX_IMAGE_DIM);   // pixel index bits
   localparam int DIM_W   = Q_W + 1;                 // image size bits
   localparam int COORD_W = 19;
   localparam int COEF_W  = 32;
   localparam int CSR_W   = 64;
   localparam int CSR_N   = 8;
   localparam int ADDR_W  = $clog2(CSR_N) + 3;

   // projection datapath widths
   localparam int PROD_W = COEF_W + COORD_W;   // one coefficient times a coordinate
   localparam int ACC_W  = PROD_W + 2;         // row sum of three products and offset
   localparam int NUM_W  = ACC_W + 3;          // 2*a + a2, signed
   localparam int CMP_W  = NUM_W + Q_W;        // divisor shifted left by up to Q_W bits

   // range datapath widths
   localparam int SQ_W   = 2 * COORD_W - 1;    // one square, unsigned
   localparam int SUM_W  = SQ_W + 1;           // sum of three squares
   localparam int ROOT_W = COORD_W;

   // pipeline depths
   localparam int PIPE_LAT  = ROOT_W + 2;
   localparam int PROJ_CORE = Q_W + 6;
   localparam int PROJ_PAD  = PIPE_LAT - PROJ_CORE;

   // register indexes
   localparam logic [2:0] REG_COEF_R0_A = 3'd0;
   localparam logic [2:0] REG_COEF_R0_B = 3'd1;
   localparam logic [2:0] REG_COEF_R1_A = 3'd2;
   localparam logic [2:0] REG_COEF_R1_B = 3'd3;
   localparam logic [2:0] REG_COEF_R2_A = 3'd4;
   localparam logic [2:0] REG_COEF_R2_B = 3'd5;
   localparam logic [2:0] REG_IMG_WIDTH = 3'd6;
   localparam logic [2:0] REG_IMG_HEIGHT = 3'd7;

   localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

   typedef struct packed {
      logic [5:0][CSR_W-1:0] coef;
      logic [DIM_W-1:0]      width;
      logic [DIM_W-1:0]      height;
   } cfg_type;

   typedef struct packed {
      logic [Q_W-1:0] col;
      logic [Q_W-1:0] row;
      logic           wr_valid;
   } pix_type;

endpackage
`default_nettype wire

// ===== rtl/core/lpdp_if.sv =====
// Channel interfaces: point transactions in, depth write transactions out.
// Depends on lpdp_pkg.
`default_nettype none
interface lpdp_req_if import lpdp_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;
   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface lpdp_rsp_if import lpdp_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [Q_W-1:0]    pixel_column;
   logic [Q_W-1:0]    pixel_row;
   logic [ROOT_W-1:0] range_mm;
   logic              write_valid;
   modport source (output valid, pixel_column, pixel_row, range_mm, write_valid,
                   input ready);
   modport sink   (input valid, pixel_column, pixel_row, range_mm, write_valid,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lpdp_csr.sv =====
// APB register file: projection coefficients and image size.
// Depends on lpdp_pkg.
`default_nettype none
module lpdp_csr import lpdp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [CSR_W-1:0]  pwdata,
   output logic [CSR_W-1:0]       prdata,
   output logic                   pready,
   output cfg_type                cfg
);
   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;

   assign idx    = paddr[ADDR_W-1:3];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (idx)
            REG_COEF_R0_A: cfg_in.coef[0] = pwdata;
            REG_COEF_R0_B: cfg_in.coef[1] = pwdata;
            REG_COEF_R1_A: cfg_in.coef[2] = pwdata;
            REG_COEF_R1_B: cfg_in.coef[3] = pwdata;
            REG_COEF_R2_A: cfg_in.coef[4] = pwdata;
            REG_COEF_R2_B: cfg_in.coef[5] = pwdata;
            REG_IMG_WIDTH: cfg_in.width = pwdata[DIM_W-1:0];
            REG_IMG_HEIGHT: cfg_in.height = pwdata[DIM_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef   <= '0;
         cfg_ff.width  <= WIDTH_RST;
         cfg_ff.height <= HEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (idx)
         REG_COEF_R0_A: prdata = cfg_ff.coef[0];
         REG_COEF_R0_B: prdata = cfg_ff.coef[1];
         REG_COEF_R1_A: prdata = cfg_ff.coef[2];
         REG_COEF_R1_B: prdata = cfg_ff.coef[3];
         REG_COEF_R2_A: prdata = cfg_ff.coef[4];
         REG_COEF_R2_B: prdata = cfg_ff.coef[5];
         REG_IMG_WIDTH: prdata = CSR_W'(cfg_ff.width);
         REG_IMG_HEIGHT: prdata = CSR_W'(cfg_ff.height);
         default: prdata = '0;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/core/lpdp_sqrt.sv =====
// Pipelined range unit: sum of squares, then one root bit per stage.
// Depends on lpdp_pkg. Advances only on enable.
`default_nettype none
module lpdp_sqrt import lpdp_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic signed [COORD_W-1:0] point_x,
   input  wire logic signed [COORD_W-1:0] point_y,
   input  wire logic signed [COORD_W-1:0] point_z,
   output logic [ROOT_W-1:0]              range_mm
);
   logic [SQ_W-1:0]  sq_ff [3];
   logic [SUM_W-1:0] rem_ff [ROOT_W+1];
   logic [SUM_W-1:0] res_ff [ROOT_W+1];
   logic [SUM_W-1:0] rem_in [ROOT_W+1];
   logic [SUM_W-1:0] res_in [ROOT_W+1];
   logic signed [2*COORD_W-1:0] px, py, pz;

   assign px = point_x * point_x;
   assign py = point_y * point_y;
   assign pz = point_z * point_z;

   // one digit-by-digit step per stage
   always_comb begin
      logic [SUM_W:0] trial;
      logic [SUM_W-1:0] bitv;
      rem_in[0] = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      res_in[0] = '0;
      for (int k = 1; k <= ROOT_W; k++) begin
         bitv  = SUM_W'(1) << (2 * (ROOT_W - k));
         trial = {1'b0, res_ff[k-1]} + {1'b0, bitv};
         if ({1'b0, rem_ff[k-1]} >= trial) begin
            rem_in[k] = rem_ff[k-1] - trial[SUM_W-1:0];
            res_in[k] = (res_ff[k-1] >> 1) + bitv;
         end else begin
            rem_in[k] = rem_ff[k-1];
            res_in[k] = res_ff[k-1] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= px[SQ_W-1:0];
         sq_ff[1] <= py[SQ_W-1:0];
         sq_ff[2] <= pz[SQ_W-1:0];
         for (int k = 0; k <= ROOT_W; k++) begin
            rem_ff[k] <= rem_in[k];
            res_ff[k] <= res_in[k];
         end
      end
   end

   assign range_mm = res_ff[ROOT_W][ROOT_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/lpdp_proj.sv =====
// Pipelined projection: matrix products, row sums, restoring division of
// column and row by depth, rounding and clamping. Depends on lpdp_pkg.
`default_nettype none
module lpdp_proj import lpdp_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire cfg_type                   cfg,
   input  wire logic signed [COORD_W-1:0] point_x,
   input  wire logic signed [COORD_W-1:0] point_y,
   input  wire logic signed [COORD_W-1:0] point_z,
   output pix_type                        pix
);
   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [NUM_W-1:0] den;
      logic [Q_W-1:0]   quo;
      logic             neg;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      lane_type [1:0] lane;
      logic           zero;
   } div_type;

   logic signed [COEF_W-1:0]  cf [3][4];
   logic signed [COORD_W-1:0] pt [3];
   logic signed [PROD_W-1:0]  mul_ff [3][3];
   logic signed [COEF_W-1:0]  off_ff [3];
   logic signed [ACC_W-1:0]   s0_ff [3], s1_ff [3], acc_ff [3];
   lane_type [1:0]            prep_in;
   lane_type [1:0]            prep_ff;
   logic                      zero_ff;
   div_type                   div_ff [Q_W+1];
   div_type                   div_in [Q_W+1];
   logic [DIM_W-1:0]          size [2];
   pix_type                   clamp_in;
   pix_type                   pad_ff [PROJ_PAD+1];

   // coefficient unpack
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         cf[r][0] = cfg.coef[2*r][CSR_W-1:COEF_W];
         cf[r][1] = cfg.coef[2*r][COEF_W-1:0];
         cf[r][2] = cfg.coef[2*r+1][CSR_W-1:COEF_W];
         cf[r][3] = cfg.coef[2*r+1][COEF_W-1:0];
      end
      pt[0] = point_x;
      pt[1] = point_y;
      pt[2] = point_z;
   end

   // numerator 2*a + a2 and divisor 2*a2, sign moved onto the numerator
   always_comb begin
      logic signed [NUM_W-1:0] n, d;
      d = NUM_W'(acc_ff[2]) <<< 1;
      for (int l = 0; l < 2; l++) begin
         n = (NUM_W'(acc_ff[l]) <<< 1) + NUM_W'(acc_ff[2]);
         if (acc_ff[2] < 0)
            n = -n;
         prep_in[l].rem = n;
         prep_in[l].den = (acc_ff[2] < 0) ? -d : d;
         prep_in[l].quo = '0;
         prep_in[l].neg = n < 0;
         prep_in[l].ovf = 1'b0;
      end
   end

   // overflow check, then one quotient bit per stage
   always_comb begin
      logic [CMP_W-1:0] sh;
      div_in[0].zero = zero_ff;
      for (int l = 0; l < 2; l++) begin
         div_in[0].lane[l]     = prep_ff[l];
         div_in[0].lane[l].ovf = {{Q_W{1'b0}}, prep_ff[l].rem} >=
                                 ({{Q_W{1'b0}}, prep_ff[l].den} << Q_W);
      end
      for (int k = 1; k <= Q_W; k++) begin
         div_in[k] = div_ff[k-1];
         for (int l = 0; l < 2; l++) begin
            sh = {{Q_W{1'b0}}, div_ff[k-1].lane[l].den} << (Q_W - k);
            if ({{Q_W{1'b0}}, div_ff[k-1].lane[l].rem} >= sh) begin
               div_in[k].lane[l].rem = div_ff[k-1].lane[l].rem - sh[NUM_W-1:0];
               div_in[k].lane[l].quo[Q_W-k] = 1'b1;
            end
         end
      end
   end

   // clamp to the image, negatives to one, zero depth to an invalid write
   always_comb begin
      logic [Q_W-1:0] q [2];
      size[0] = (cfg.width == '0) ? DIM_W'(1) :
                (cfg.width > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : cfg.width;
      size[1] = (cfg.height == '0) ? DIM_W'(1) :
                (cfg.height > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : cfg.height;
      for (int l = 0; l < 2; l++) begin
         q[l] = div_ff[Q_W].lane[l].quo;
         if (div_ff[Q_W].lane[l].ovf || ({1'b0, q[l]} >= size[l]))
            q[l] = Q_W'(size[l] - DIM_W'(1));
         if (div_ff[Q_W].lane[l].neg)
            q[l] = Q_W'(1);
         if (div_ff[Q_W].zero)
            q[l] = '0;
      end
      clamp_in.col      = q[0];
      clamp_in.row      = q[1];
      clamp_in.wr_valid = !div_ff[Q_W].zero;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++)
               mul_ff[r][c] <= cf[r][c] * pt[c];
            off_ff[r] <= cf[r][3];
            s0_ff[r]  <= ACC_W'(mul_ff[r][0]) + ACC_W'(mul_ff[r][1]);
            s1_ff[r]  <= ACC_W'(mul_ff[r][2]) + ACC_W'(off_ff[r]);
            acc_ff[r] <= s0_ff[r] + s1_ff[r];
         end
         prep_ff <= prep_in;
         zero_ff <= acc_ff[2] == '0;
         for (int k = 0; k <= Q_W; k++)
            div_ff[k] <= div_in[k];
         pad_ff[0] <= clamp_in;
         for (int k = 1; k <= PROJ_PAD; k++)
            pad_ff[k] <= pad_ff[k-1];
      end
   end

   assign pix = pad_ff[PROJ_PAD];
endmodule
`default_nettype wire

// ===== rtl/core/lidar_point_depth_projection.sv =====
// Top level: lidar point to depth image write command.
// Depends on lpdp_pkg, lpdp_if, lpdp_csr, lpdp_sqrt, lpdp_proj.
//
//   channel  | dir | payload
//   req_ch   | in  | point_x, point_y, point_z (signed mm)
//   rsp_ch   | out | pixel_column, pixel_row, range_mm, write_valid
//   psel..   | in  | APB, 64-bit registers at 8*index
//
// One transaction in per cycle unless stalled; each result passes the
// square and sum stages, then the 19 root stages (the projection path is
// padded to match). The whole pipeline advances together: it stalls only
// when a result waits at the output and rsp_ch.ready is low.
// Synchronous reset clears valid bits and coefficients, size to 640x480.
`default_nettype none
module lidar_point_depth_projection import lpdp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   lpdp_req_if.sink               req_ch,
   lpdp_rsp_if.source             rsp_ch,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [CSR_W-1:0]  pwdata,
   output logic [CSR_W-1:0]       prdata,
   output logic                   pready
);
   cfg_type               cfg;
   pix_type               pix;
   logic                  en;
   logic [PIPE_LAT-1:0]   vld_ff, vld_in;
   logic [ROOT_W-1:0]     range_mm;

   lpdp_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready, .cfg
   );

   lpdp_sqrt u_sqrt (
      .clock, .en,
      .point_x (req_ch.point_x),
      .point_y (req_ch.point_y),
      .point_z (req_ch.point_z),
      .range_mm
   );

   lpdp_proj u_proj (
      .clock, .en, .cfg,
      .point_x (req_ch.point_x),
      .point_y (req_ch.point_y),
      .point_z (req_ch.point_z),
      .pix
   );

   // global advance: move unless a finished result is held
   assign en           = !vld_ff[PIPE_LAT-1] || rsp_ch.ready;
   assign req_ch.ready = en;
   assign vld_in       = {vld_ff[PIPE_LAT-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_ch.valid        = vld_ff[PIPE_LAT-1];
   assign rsp_ch.pixel_column = pix.col;
   assign rsp_ch.pixel_row    = pix.row;
   assign rsp_ch.write_valid  = pix.wr_valid;
   assign rsp_ch.range_mm     = range_mm;
endmodule
`default_nettype wire

// ===== rtl/core/lpdp_checker.sv =====
// Port-level checks for the projection block, bound to the top level.
// Depends on lpdp_pkg.
`default_nettype none
module lpdp_checker import lpdp_pkg::*; (
   input wire logic           clock,
   input wire logic           reset,
   input wire logic           req_ready,
   input wire logic           rsp_valid,
   input wire logic           rsp_ready,
   input wire logic           write_valid,
   input wire logic [Q_W-1:0] pixel_column,
   input wire logic [Q_W-1:0] pixel_row
);
   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input is taken exactly when the output is free to move
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready not tied to output flow");

   // a held result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // zero depth writes carry a zero pixel
   a_zero_pix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !write_valid |-> pixel_column == '0 && pixel_row == '0)
      else $error("invalid write with nonzero pixel");
endmodule

bind lidar_point_depth_projection lpdp_checker u_lpdp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .write_valid  (rsp_ch.write_valid),
   .pixel_column (rsp_ch.pixel_column),
   .pixel_row    (rsp_ch.pixel_row)
);
`default_nettype wire

// ===== bench/lpdp_scoreboard.sv =====
// Checker for the lidar point depth projection block: watches both channels,
// predicts each depth write from the point and the mirrored registers, compares.
// Depends on lpdp_pkg and lpdp_if.
`timescale 1ns / 100ps
`default_nettype none
module lpdp_scoreboard import lpdp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic signed [COORD_W-1:0] req_x,
   input  wire logic signed [COORD_W-1:0] req_y,
   input  wire logic signed [COORD_W-1:0] req_z,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [Q_W-1:0]    rsp_col,
   input  wire logic [Q_W-1:0]    rsp_row,
   input  wire logic [ROOT_W-1:0] rsp_range,
   input  wire logic              rsp_wv,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [CSR_W-1:0]  pwdata,
   input  wire logic              pready,
   output int                     fail_count,
   output int                     pending
);

   typedef struct packed {
      logic [Q_W-1:0]    col;
      logic [Q_W-1:0]    row;
      logic [ROOT_W-1:0] range_mm;
      logic              wv;
   } depth_write_type;

   logic [CSR_W-1:0] coef_mirror [6];
   logic [12:0]      width_mirror, height_mirror;
   depth_write_type  expected_writes [$];

   assign pending = expected_writes.size();

   // floor square root by binary restoring method
   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 40;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v  -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint coef_at(int r, int c);
      logic [CSR_W-1:0] w;
      w = coef_mirror[r*2 + c/2];
      return (c % 2) ? longint'($signed(w[31:0])) : longint'($signed(w[63:32]));
   endfunction

   // rounded half-up pixel index, clamped to the image
   function automatic longint round_clamp(longint a, longint a2, logic [12:0] sz_raw);
      longint n, d, q, sz;
      sz = (sz_raw == 0) ? 1 : (sz_raw > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : sz_raw;
      n = 2*a + a2;
      d = 2*a2;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      q = (n >= 0) ? n / d : -(((-n) + d - 1) / d);
      if (q >= sz) q = sz - 1;
      if (q < 0) q = 1;
      return q;
   endfunction

   function automatic depth_write_type project_point(longint x, longint y, longint z);
      depth_write_type w;
      longint          acc [3];
      longint          pt [3];
      pt = '{x, y, z};
      for (int r = 0; r < 3; r++) begin
         acc[r] = coef_at(r, 3);
         for (int c = 0; c < 3; c++) acc[r] += coef_at(r, c) * pt[c];
      end
      w.range_mm = ROOT_W'(floor_root(longint'(x*x + y*y + z*z)));
      if (acc[2] == 0) begin
         w.col = '0;
         w.row = '0;
         w.wv  = 1'b0;
      end else begin
         w.col = Q_W'(round_clamp(acc[0], acc[2], width_mirror));
         w.row = Q_W'(round_clamp(acc[1], acc[2], height_mirror));
         w.wv  = 1'b1;
      end
      return w;
   endfunction

   always @(posedge clock) begin
      depth_write_type e;
      int              errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < 6; i++) coef_mirror[i] <= '0;
         width_mirror  <= 13'd640;
         height_mirror <= 13'd480;
         expected_writes.delete();
         fail_count <= 0;
      end else begin
         // register write mirror
         if (psel && penable && pwrite && pready) begin
            if (paddr[ADDR_W-1:3] <= REG_COEF_R2_B)
               coef_mirror[paddr[ADDR_W-1:3]] <= pwdata;
            else if (paddr[ADDR_W-1:3] == REG_IMG_WIDTH) width_mirror <= pwdata[12:0];
            else height_mirror <= pwdata[12:0];
         end
         // point transaction in
         if (req_valid && req_ready)
            expected_writes = {expected_writes, project_point(req_x, req_y, req_z)};
         // depth write transaction out
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               $error("unexpected depth write transaction");
               errs = errs + 1;
            end else begin
               e = expected_writes.pop_front();
               if (e.col !== rsp_col) begin
                  $error("pixel_column expected %0d actual %0d", e.col, rsp_col);
                  errs = errs + 1;
               end
               if (e.row !== rsp_row) begin
                  $error("pixel_row expected %0d actual %0d", e.row, rsp_row);
                  errs = errs + 1;
               end
               if (e.range_mm !== rsp_range) begin
                  $error("range_mm expected %0d actual %0d", e.range_mm, rsp_range);
                  errs = errs + 1;
               end
               if (e.wv !== rsp_wv) begin
                  $error("write_valid expected %0d actual %0d", e.wv, rsp_wv);
                  errs = errs + 1;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule
`default_nettype wire

// ===== bench/lidar_point_depth_projection_tb.sv =====
// Testbench top for the lidar point depth projection block: drives points
// and register writes, stalls the output, and reports the verdict.
// Depends on lpdp_pkg, lpdp_if, lpdp_scoreboard and the block itself.
`timescale 1ns / 100ps
`default_nettype none
module lidar_point_depth_projection_tb;
   import lpdp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = PIPE_LAT + 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [CSR_W-1:0]  pwdata = '0;
   logic [CSR_W-1:0]  prdata;
   logic              pready;
   int fail_count, pending;
   int idle_cycles = 0;
   bit long_hold = 1'b0;
   bit sending_done = 1'b0;

   lpdp_req_if req_ch ();
   lpdp_rsp_if rsp_ch ();

   always #6 clock = ~clock;

   lidar_point_depth_projection dut (
      .clock, .reset, .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   lpdp_scoreboard checker_i (
      .clock, .reset,
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_x(req_ch.point_x), .req_y(req_ch.point_y), .req_z(req_ch.point_z),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_col(rsp_ch.pixel_column), .rsp_row(rsp_ch.pixel_row),
      .rsp_range(rsp_ch.range_mm), .rsp_wv(rsp_ch.write_valid),
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .fail_count, .pending
   );

   // receiver stall pattern, with one long hold-off on request
   always @(posedge clock) begin
      int hold;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (long_hold) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         hold = $urandom_range(0, 9);
         rsp_ch.ready <= (hold < 6) || sending_done;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || long_hold)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [CSR_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // send one point; valid stays high for back-to-back transactions
   task automatic send_point(logic signed [COORD_W-1:0] x, y, z, bit keep);
      req_ch.valid   <= 1'b1;
      req_ch.point_x <= x;
      req_ch.point_y <= y;
      req_ch.point_z <= z;
      do @(posedge clock); while (!req_ch.ready);
      if (!keep) req_ch.valid <= 1'b0;
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0:       return COORD_W'($urandom);
         1:       return $urandom_range(0, 1) ? 19'sh3FFFF : -19'sh40000;
         2:       return COORD_W'($signed($urandom_range(0, 20)) - 10);
         default: return COORD_W'($signed($urandom_range(0, 80000)) - 40000);
      endcase
   endfunction

   // realistic intrinsics scaled: fx, cx packed into rows; depth row from z
   task automatic load_camera(int fx, int cx, int fy, int cy, logic [12:0] w, h);
      csr_write(REG_COEF_R0_A, {32'(fx << 16), 32'(0)});
      csr_write(REG_COEF_R0_B, {32'(cx << 16), 32'($urandom_range(0, 65535))});
      csr_write(REG_COEF_R1_A, {32'(0), 32'(fy << 16)});
      csr_write(REG_COEF_R1_B, {32'(cy << 16), 32'($urandom_range(0, 65535))});
      csr_write(REG_COEF_R2_A, {32'($urandom_range(0, 3)), 32'($urandom_range(0, 3))});
      csr_write(REG_COEF_R2_B, {32'(1 << 16), 32'(0)});
      csr_write(REG_IMG_WIDTH, {51'd0, w});
      csr_write(REG_IMG_HEIGHT, {51'd0, h});
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // bursts of points; valid stays high across a burst boundary with no gap
   task automatic random_phase(int count);
      int burst;
      int gap;
      while (count > 0) begin
         burst = $urandom_range(1, 12);
         gap   = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
         for (int i = 0; i < burst && count > 0; i++, count--)
            send_point(rand_coord(), rand_coord(), rand_coord(),
                       (i < burst - 1 || gap == 0) && count > 1);
         if (gap != 0) repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.point_z = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: all coefficients zero, so every depth is zero
      send_point(19'sh3FFFF, 19'sh3FFFF, 19'sh3FFFF, 1'b1);
      send_point(-19'sh40000, -19'sh40000, -19'sh40000, 1'b1);
      send_point('0, '0, '0, 1'b0);
      wait_drained();

      // directed: projection with a plain camera at default size
      load_camera(500, 320, 500, 240, 13'd640, 13'd480);
      send_point(0, 0, 1000, 1'b1);          // image center
      send_point(1000, 1000, 1000, 1'b1);    // clamps high on both axes
      send_point(-1000, -1000, 1000, 1'b1);  // negative pixel goes to 1
      send_point(1, 1, 2, 1'b1);             // half-pixel rounding
      send_point(0, 0, -1000, 1'b1);         // point behind camera
      send_point(0, 0, 0, 1'b1);             // depth equals offset only
      send_point(19'sh3FFFF, -19'sh40000, 19'sh3FFFF, 1'b1);
      send_point(-19'sh40000, 19'sh3FFFF, 1, 1'b0);
      wait_drained();

      // zero depth with nonzero offsets, extremes of the coefficients
      csr_write(REG_COEF_R2_A, 64'd0);
      csr_write(REG_COEF_R2_B, 64'd0);
      csr_write(REG_COEF_R0_A, 64'h7FFF_FFFF_8000_0000);
      send_point(12, 34, 56, 1'b0);
      wait_drained();
      csr_write(REG_COEF_R2_B, 64'h8000_0000_7FFF_FFFF);
      csr_write(REG_COEF_R1_B, 64'hFFFF_FFFF_FFFF_FFFF);
      send_point(19'sh3FFFF, 19'sh3FFFF, 19'sh3FFFF, 1'b1);
      send_point(-19'sh40000, -19'sh40000, -19'sh40000, 1'b1);
      send_point(5, -7, 0, 1'b0);
      wait_drained();

      // size extremes: 1x1, 0 acting as 1, above max, max
      load_camera(500, 0, 500, 0, 13'd1, 13'd0);
      send_point(-500, -500, 1000, 1'b1);
      send_point(500, 500, 1000, 1'b0);
      wait_drained();
      load_camera(900, 2048, 900, 2048, 13'h1FFF, 13'd4096);
      send_point(100000, 100000, 1000, 1'b1);
      send_point(-3, 3, 1000, 1'b0);
      wait_drained();

      // random phases with varied cameras and fully random matrices
      for (int ph = 0; ph < 6; ph++) begin
         if (ph % 2 == 0) begin
            load_camera($urandom_range(1, 2000), $urandom_range(0, 4000),
                        $urandom_range(1, 2000), $urandom_range(0, 4000),
                        13'($urandom_range(0, 8191)), 13'($urandom_range(1, 4096)));
         end else begin
            for (int r = 0; r < 6; r++)
               csr_write(3'(r), {$urandom, $urandom});
            csr_write(REG_IMG_WIDTH, {51'd0, 13'($urandom)});
            csr_write(REG_IMG_HEIGHT, {51'd0, 13'($urandom)});
         end
         if (ph == 2) begin
            // long receiver hold-off while points keep coming
            fork
               begin
                  long_hold = 1'b1;
                  repeat (300) @(posedge clock);
                  long_hold = 1'b0;
               end
               random_phase(105);
            join
         end else begin
            random_phase(105);
         end
         wait_drained();
      end

      sending_done = 1'b1;
      wait_drained();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/lpdp_pkg.sv
rtl/core/lpdp_if.sv
rtl/core/lpdp_csr.sv
rtl/core/lpdp_sqrt.sv
rtl/core/lpdp_proj.sv
rtl/core/lidar_point_depth_projection.sv
rtl/core/lpdp_checker.sv
bench/lpdp_scoreboard.sv
bench/lidar_point_depth_projection_tb.sv
